@@ rtl/llc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache package
// Shared sizes, register map and controller/datapath command types.
// ----------------------------------------------------------------------------
package llc_pkg;

	localparam int ENTRIES   = 8;
	localparam int KEY_WIDTH = 64;

	localparam int TAG_W  = 64;
	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int CAP_W  = 4;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int REG_W  = APB_AW - 2;

	localparam logic [REG_W-1:0] REG_CAPACITY = REG_W'(0);

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} llc_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} llc_sts_t;

endpackage

@@ rtl/llc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface llc_req_if import llc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [TAG_W-1:0]  key_tag;
	logic [IP_W-1:0]   ip_addr;
	logic [PORT_W-1:0] port_num;

	modport source (output valid, kind, key_tag, ip_addr, port_num, input ready);
	modport sink   (input valid, kind, key_tag, ip_addr, port_num, output ready);
endinterface

interface llc_rsp_if import llc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [IP_W-1:0]   ip_out;
	logic [PORT_W-1:0] port_out;
	logic              evicted;

	modport source (output valid, hit, ip_out, port_out, evicted, input ready);
	modport sink   (input valid, hit, ip_out, port_out, evicted, output ready);
endinterface

@@ rtl/lru_lookup_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache
// Fully associative key-to-address/port cache with least-recent eviction.
// ----------------------------------------------------------------------------
// One transaction at a time: a request is taken only after the last one commits;
//   the serial key scan reads one entry per cycle through a single comparator.
// A finished response waits in its register while the next request is taken.
// Reset: live count and ranks clear at once, capacity returns to 3; entry
//   contents stay undefined and no clearing pass runs.
// ----------------------------------------------------------------------------
module lru_lookup_cache import llc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	llc_req_if.sink           req,
	llc_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	llc_cmd_t         cmd;
	llc_sts_t         sts;
	logic [CAP_W-1:0] capacity;

	llc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	llc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	llc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.capacity    (capacity),
		.in_kind     (req.kind),
		.in_key      (req.key_tag),
		.in_ip       (req.ip_addr),
		.in_port     (req.port_num),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_hit     (rsp.hit),
		.out_ip      (rsp.ip_out),
		.out_port    (rsp.port_out),
		.out_evicted (rsp.evicted)
	);

endmodule

@@ rtl/llc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache register file
// APB-style slave holding the capacity register.
// ----------------------------------------------------------------------------
module llc_cfg import llc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [CAP_W-1:0]  capacity
);

	logic [CAP_W-1:0] capacity_q;
	logic             wr_en;
	logic             sel_cap;

	assign pready   = 1'b1;
	assign sel_cap  = (paddr[APB_AW-1:2] == REG_CAPACITY);
	assign wr_en    = psel && penable && pwrite && pready;
	assign prdata   = sel_cap ? APB_DW'(capacity_q) : '0;
	assign capacity = capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_en && sel_cap) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

endmodule

@@ rtl/llc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache controller
// Sequences accept, entry scan and commit of one transaction at a time.
// ----------------------------------------------------------------------------
module llc_ctrl import llc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  llc_sts_t sts,
	output llc_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.load   = in_ready && in_valid;
		cmd.step   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_FINISH) && sts.out_free;
	end

endmodule

@@ rtl/llc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache datapath
// Entry storage, recency ranks, serial key scan and response register.
// ----------------------------------------------------------------------------
module llc_dp import llc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  llc_cmd_t          cmd,
	output llc_sts_t          sts,
	input  logic [CAP_W-1:0]  capacity,
	input  logic              in_kind,
	input  logic [TAG_W-1:0]  in_key,
	input  logic [IP_W-1:0]   in_ip,
	input  logic [PORT_W-1:0] in_port,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_hit,
	output logic [IP_W-1:0]   out_ip,
	output logic [PORT_W-1:0] out_port,
	output logic              out_evicted
);

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic                 kind_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [IP_W-1:0]      ip_q;
	logic [PORT_W-1:0]    port_q;

	logic [KEY_WIDTH-1:0] slot_key_q  [ENTRIES];
	logic [IP_W-1:0]      slot_ip_q   [ENTRIES];
	logic [PORT_W-1:0]    slot_port_q [ENTRIES];
	logic [IDX_W-1:0]     slot_rank_q [ENTRIES];
	logic [CNT_W-1:0]     live_q;

	logic [IDX_W-1:0] idx_q;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [IDX_W-1:0] best_rank_q;
	logic [IDX_W-1:0] lru_idx_q;

	logic              out_valid_q;
	logic              hit_q;
	logic [IP_W-1:0]   ip_out_q;
	logic [PORT_W-1:0] port_out_q;
	logic              evicted_q;

	logic [IDX_W-1:0] cur_rank;
	logic             cur_live;
	logic             cur_match;
	logic             cur_lru;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic             evict;
	logic [IDX_W-1:0] wslot;
	logic [IDX_W-1:0] target;
	logic [CNT_W-1:0] limit;
	logic             apply;
	logic             hit_now;

	assign cur_rank  = slot_rank_q[idx_q];
	assign cur_live  = CNT_W'(idx_q) < live_q;
	assign cur_match = cur_live && (slot_key_q[idx_q] == key_q)
		&& (!found_q || (cur_rank < best_rank_q));
	assign cur_lru   = cur_live && (CNT_W'(cur_rank) == (live_q - CNT_W'(1)));

	assign sts.scan_last = (CNT_W'(idx_q) + CNT_W'(1)) >= live_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		evict   = kind_q && (CMP_W'(live_q) >= eff_cap);
		wslot   = evict ? lru_idx_q : live_q[IDX_W-1:0];
		target  = kind_q ? wslot : best_idx_q;
		hit_now = !kind_q && found_q;
		apply   = kind_q || found_q;
		if (kind_q) begin
			limit = evict ? (live_q - CNT_W'(1)) : live_q;
		end else begin
			limit = CNT_W'(best_rank_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			key_q  <= in_key[KEY_WIDTH-1:0];
			ip_q   <= in_ip;
			port_q <= in_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_rank_q <= '0;
			lru_idx_q   <= '0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			if (!sts.scan_last) idx_q <= idx_q + IDX_W'(1);
			if (cur_match) begin
				found_q     <= 1'b1;
				best_idx_q  <= idx_q;
				best_rank_q <= cur_rank;
			end
			if (cur_lru) lru_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_rank_q[i] <= '0;
			end
		end else if (cmd.commit && apply) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if ((CNT_W'(i) < live_q) && (CNT_W'(slot_rank_q[i]) < limit)) begin
					slot_rank_q[i] <= slot_rank_q[i] + IDX_W'(1);
				end
			end
			slot_rank_q[target] <= '0;
			if (kind_q && !evict) live_q <= live_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && kind_q) begin
			slot_key_q[wslot]  <= key_q;
			slot_ip_q[wslot]   <= ip_q;
			slot_port_q[wslot] <= port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q      <= hit_now;
			ip_out_q   <= hit_now ? slot_ip_q[best_idx_q] : '0;
			port_out_q <= hit_now ? slot_port_q[best_idx_q] : '0;
			evicted_q  <= evict;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_hit     = hit_q;
	assign out_ip      = ip_out_q;
	assign out_port    = port_out_q;
	assign out_evicted = evicted_q;

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(ENTRIES))
		else $error("live count above table depth");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("commit while response register is held");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("response not presented after commit");

	a_live_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(live_q))
		else $error("live count changed outside commit");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (idx_q == '0) && !found_q)
		else $error("scan not restarted on load");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU lookup cache testbench
// Drives lookup and insert transactions with random idle and stall patterns,
// predicts each response with an independent LRU table model (a directed
// row may give its own) and checks it field by field. Capacity is set anew
// between phases, including zero, the table depth and values above it.
// ----------------------------------------------------------------------------
module tb_top;
	import llc_pkg::*;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_kind_e;

	typedef struct packed {
		op_kind_e          kind;
		logic [TAG_W-1:0]  key;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
	} llc_req_t;

	typedef struct packed {
		logic              hit;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic              evicted;
	} llc_rsp_t;

	typedef struct packed {
		logic              cfg;
		logic [CAP_W-1:0]  cap;
		op_kind_e          kind;
		logic [TAG_W-1:0]  key;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic              typed;
		llc_rsp_t          want;
	} dir_row_t;

	localparam logic [APB_AW-1:0] ADDR_CAP      = APB_AW'({REG_CAPACITY, 2'b00});
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED = ADDR_CAP ^ APB_AW'(4);
	localparam logic [TAG_W-1:0]  KEY_MASK      = TAG_W'({KEY_WIDTH{1'b1}});
	localparam logic [TAG_W-1:0]  K_ONES        = '1;
	localparam int                POOL_N        = 12;
	localparam int                PHASES        = 8;
	localparam int                PHASE_ITEMS   = 75;
	localparam int                IDLE_LIMIT    = 4000;
	localparam int                TAIL_CYCLES   = 20;

	localparam llc_rsp_t RSP_ZERO  = '0;
	localparam llc_rsp_t RSP_EVICT = '{1'b0, 32'h0, 16'h0, 1'b1};
	localparam llc_rsp_t RSP_FULL  = '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0};

	localparam dir_row_t DIR_TAB [0:21] = '{
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h0,  32'h1234_5678, 16'hBEEF, 1'b1, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'h0,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h0,  32'h0,         16'h0,    1'b1, RSP_FULL},
		'{1'b0, 4'd0,  OP_INSERT, K_ONES, 32'h0,         16'h0,    1'b1, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'h5,  32'h1,         16'h1,    1'b1, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'h5,  32'h2,         16'h2,    1'b1, RSP_EVICT},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h5,  32'hFFFF_FFFF, 16'hFFFF, 1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h0,  32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, K_ONES, 32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b1, 4'd0,  OP_INSERT, 64'h7,  32'hA5A5_A5A5, 16'h5A5A, 1'b1, RSP_EVICT},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h7,  32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b1, 4'd15, OP_INSERT, 64'h8,  32'h8,         16'h8,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'h9,  32'h9,         16'h9,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'hA,  32'hA,         16'hA,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'hB,  32'hB,         16'hB,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'hC,  32'hC,         16'hC,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_INSERT, 64'hD,  32'hD,         16'hD,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h9,  32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b1, 4'd2,  OP_INSERT, 64'hE,  32'hE,         16'hE,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'hE,  32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'h8,  32'h0,         16'h0,    1'b0, RSP_ZERO},
		'{1'b0, 4'd0,  OP_LOOKUP, 64'hAAAA_5555_AAAA_5555, 32'h0, 16'h0, 1'b0, RSP_ZERO}
	};

	localparam logic [CAP_W-1:0] CAP_PLAN [0:6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd3};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	llc_req_if req ();
	llc_rsp_if rsp ();

	lru_lookup_cache u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req.sink),
		.rsp     (rsp.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted table contents and recency
	logic [TAG_W-1:0]  lru_key  [ENTRIES];
	logic [IP_W-1:0]   lru_ip   [ENTRIES];
	logic [PORT_W-1:0] lru_port [ENTRIES];
	int                lru_rank [ENTRIES];
	int                lru_live = 0;
	logic [CAP_W-1:0]  lru_cap  = CAP_RESET;

	llc_rsp_t          pending_rsp_q [$];
	logic [TAG_W-1:0]  key_pool [POOL_N];

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int fail_count    = 0;
	int idle_cycles   = 0;
	int n_items       = 0;
	int n_hits        = 0;
	int n_evicts      = 0;
	int n_caps        = 0;

	always #10 clk = ~clk;

	function automatic void age_ranks(int limit);
		for (int i = 0; i < lru_live && i < ENTRIES; i++)
			if (lru_rank[i] < limit)
				lru_rank[i]++;
	endfunction

	function automatic llc_rsp_t lru_predict(llc_req_t r);
		llc_rsp_t         o;
		logic [TAG_W-1:0] k;
		int               eff;
		int               slot;
		int               best;
		bit               found;
		o     = '0;
		k     = r.key & KEY_MASK;
		eff   = (lru_cap == 0) ? 1 : ((int'(lru_cap) > ENTRIES) ? ENTRIES : int'(lru_cap));
		found = 1'b0;
		best  = 0;
		if (r.kind == OP_INSERT) begin
			if (lru_live >= eff && lru_live > 0) begin
				slot = 0;
				for (int i = 0; i < lru_live && i < ENTRIES; i++)
					if (lru_rank[i] == lru_live - 1)
						slot = i;
				age_ranks(lru_live - 1);
				o.evicted = 1'b1;
			end else begin
				slot = lru_live;
				age_ranks(lru_live);
				lru_live++;
			end
			if (slot < ENTRIES) begin
				lru_key[slot]  = k;
				lru_ip[slot]   = r.ip;
				lru_port[slot] = r.port;
				lru_rank[slot] = 0;
			end
		end else begin
			for (int i = 0; i < lru_live && i < ENTRIES; i++) begin
				if (lru_key[i] == k && (!found || lru_rank[i] < lru_rank[best])) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (found) begin
				age_ranks(lru_rank[best]);
				lru_rank[best] = 0;
				o.hit  = 1'b1;
				o.ip   = lru_ip[best];
				o.port = lru_port[best];
			end
		end
		return o;
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input llc_req_t r);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid    <= 1'b1;
		req.kind     <= r.kind;
		req.key_tag  <= r.key;
		req.ip_addr  <= r.ip;
		req.port_num <= r.port;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic issue(input llc_req_t r, input bit typed, input llc_rsp_t typed_rsp);
		llc_rsp_t want;
		send_req(r);
		want = lru_predict(r);
		if (typed)
			want = typed_rsp;
		pending_rsp_q.push_back(want);
		n_items++;
		if (want.hit)
			n_hits++;
		if (want.evicted)
			n_evicts++;
	endtask

	task automatic wait_drain();
		req.valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
				input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b1, ADDR_CAP, APB_DW'(cap) | (APB_DW'($urandom) << CAP_W), rd);
		lru_cap = cap;
		// unmapped register: must leave capacity alone
		apb_xfer(1'b1, ADDR_UNMAPPED, APB_DW'($urandom), rd);
		apb_xfer(1'b0, ADDR_CAP, '0, rd);
		if (rd[CAP_W-1:0] !== lru_cap) begin
			fail_count++;
			if (fail_count <= 10)
				$display("capacity readback: expected %0d got %0d", lru_cap, rd[CAP_W-1:0]);
		end
		n_caps++;
	endtask

	// response sink: ready changes at the falling edge
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// response check and watchdog
	always @(posedge clk) begin
		llc_rsp_t got;
		llc_rsp_t want;
		got = '{rsp.hit, rsp.ip_out, rsp.port_out, rsp.evicted};
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected transaction: hit=%0b ip=%h port=%h evicted=%0b",
						got.hit, got.ip, got.port, got.evicted);
			end else begin
				want = pending_rsp_q.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$write("mismatch: expected hit=%0b ip=%h port=%h evicted=%0b,",
							want.hit, want.ip, want.port, want.evicted);
						$display(" got hit=%0b ip=%h port=%h evicted=%0b",
							got.hit, got.ip, got.port, got.evicted);
					end
				end
			end
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		llc_req_t         r;
		logic [CAP_W-1:0] cap;
		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.kind     = OP_LOOKUP;
		req.key_tag  = '0;
		req.ip_addr  = '0;
		req.port_num = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		key_pool[0]  = '0;
		key_pool[1]  = K_ONES;
		for (int i = 2; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < ENTRIES; i++)
			lru_rank[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_TAB[i]) begin
			if (DIR_TAB[i].cfg) begin
				wait_drain();
				set_capacity(DIR_TAB[i].cap);
			end
			r = '{DIR_TAB[i].kind, DIR_TAB[i].key, DIR_TAB[i].ip, DIR_TAB[i].port};
			issue(r, DIR_TAB[i].typed, DIR_TAB[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_drain();
			cap = (p < 7) ? CAP_PLAN[p] : CAP_W'($urandom_range(0, 15));
			set_capacity(cap);
			case (p % 4)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 49;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 49;
				end
				default: begin
					src_idle_pct  = 36;
					snk_stall_pct = 36;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r.kind = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
				r.key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_N-1)]
								      : {$urandom, $urandom};
				r.ip   = $urandom;
				r.port = PORT_W'($urandom);
				issue(r, 1'b0, RSP_ZERO);
			end
		end

		src_idle_pct  = 0;
		snk_stall_pct = 0;
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d transactions: %0d lookup hits, %0d evicting inserts",
			n_items, n_hits, n_evicts);
		$display("across %0d capacity settings and four idle/stall profiles", n_caps);
		if (fail_count == 0 && pending_rsp_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/llc_pkg.sv
rtl/llc_if.sv
rtl/llc_cfg.sv
rtl/llc_ctrl.sv
rtl/llc_dp.sv
rtl/lru_lookup_cache.sv
tb/sv/tb_top.sv
